>>> sv/thcb_pkg.sv
package thcb_pkg;

  localparam int ALT_WIDTH       = 16;
  localparam int SUM_WIDTH       = ALT_WIDTH + 2;
  localparam int DIFF_WIDTH      = SUM_WIDTH + 1;
  localparam int NUM_LEVELS      = 4;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int Q_BITS          = 7;
  localparam int QCNT_WIDTH      = $clog2(Q_BITS + 1);
  localparam int CHAN_WIDTH      = 8;
  localparam int ACC_WIDTH       = 2 * CHAN_WIDTH;
  localparam int OP_WIDTH        = 2;
  localparam int BAND_WIDTH      = 3;

  localparam logic [OP_WIDTH-1:0] OP_TRACK = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_COLOR = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WATER_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAND_TOP    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRASS_TOP   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROCK_TOP    = 2'd3;

  localparam logic [BAND_WIDTH-1:0] BAND_WATER = 3'd0;
  localparam logic [BAND_WIDTH-1:0] BAND_SAND  = 3'd1;
  localparam logic [BAND_WIDTH-1:0] BAND_GRASS = 3'd2;
  localparam logic [BAND_WIDTH-1:0] BAND_ROCK  = 3'd3;
  localparam logic [BAND_WIDTH-1:0] BAND_SNOW  = 3'd4;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [BAND_WIDTH-1:0]        band;
    logic signed [DIFF_WIDTH-1:0] num;
    logic signed [DIFF_WIDTH-1:0] den;
  } job_t;

  typedef struct packed {
    logic [CHAN_WIDTH-1:0] blue;
    logic [CHAN_WIDTH-1:0] green;
    logic [CHAN_WIDTH-1:0] red;
  } bgr_t;

  function automatic bgr_t band_color(input logic [BAND_WIDTH-1:0] band);
    bgr_t c;
    unique case (band)
      BAND_WATER: c = '{blue: 8'd255, green: 8'd100, red: 8'd0};
      BAND_SAND:  c = '{blue: 8'd0,   green: 8'd200, red: 8'd255};
      BAND_GRASS: c = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
      BAND_ROCK:  c = '{blue: 8'd128, green: 8'd128, red: 8'd128};
      default:    c = '{blue: 8'd255, green: 8'd255, red: 8'd255};
    endcase
    return c;
  endfunction

  function automatic logic signed [ALT_WIDTH-1:0] level_reset(
      input logic [CFG_INDEX_WIDTH-1:0] idx);
    logic signed [ALT_WIDTH-1:0] v;
    unique case (idx)
      REG_WATER_LEVEL: v = ALT_WIDTH'(0);
      REG_SAND_TOP:    v = ALT_WIDTH'(1024);
      REG_GRASS_TOP:   v = ALT_WIDTH'(4096);
      default:         v = ALT_WIDTH'(8192);
    endcase
    return v;
  endfunction

endpackage

>>> sv/thcb_if.sv
interface thcb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [thcb_pkg::OP_WIDTH-1:0]          opcode;
  logic signed [thcb_pkg::ALT_WIDTH-1:0]  corner_a;
  logic signed [thcb_pkg::ALT_WIDTH-1:0]  corner_b;
  logic signed [thcb_pkg::ALT_WIDTH-1:0]  corner_c;
  logic signed [thcb_pkg::ALT_WIDTH-1:0]  corner_d;

  modport source (output valid, opcode, corner_a, corner_b, corner_c, corner_d,
                  input ready);
  modport sink (input valid, opcode, corner_a, corner_b, corner_c, corner_d,
                output ready);
endinterface

interface thcb_out_if;
  logic                                valid;
  logic                                ready;
  logic [thcb_pkg::CHAN_WIDTH-1:0]     blue;
  logic [thcb_pkg::CHAN_WIDTH-1:0]     green;
  logic [thcb_pkg::CHAN_WIDTH-1:0]     red;
  logic [thcb_pkg::BAND_WIDTH-1:0]     band;

  modport source (output valid, blue, green, red, band, input ready);
  modport sink (input valid, blue, green, red, band, output ready);
endinterface

interface thcb_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [thcb_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [thcb_pkg::ALT_WIDTH-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/terrain_height_color_banding.sv
// Flow: a color transaction passes S_IDLE (accept), S_CLASS, S_LOAD, S_RUN (the
//   bit-serial divide/scale loop in thcb_serial) and S_DONE, which waits on ready.
//   A new transaction is taken only back in S_IDLE; track, clear and unused
//   opcodes return from S_CLASS to S_IDLE with no result.
// Reset (rst, synchronous): thresholds return to 0/1024/4096/8192, extremes to
//   largest/most negative sums, output register empty. No clearing pass.
module terrain_height_color_banding (
  input  logic        clk,
  input  logic        rst,
  thcb_cfg_if.sink    cfg,
  thcb_in_if.sink     item,
  thcb_out_if.source  result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [thcb_pkg::OP_WIDTH-1:0]  op;
  thcb_pkg::job_t                 job;
  thcb_pkg::bgr_t                 color;
  logic                           ser_busy;
  logic                           in_fire;
  logic                           out_free;

  assign item.ready = (state == S_IDLE);
  assign in_fire    = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;

  thcb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .capture  (in_fire),
    .classify (state == S_CLASS),
    .opcode   (item.opcode),
    .corner_a (item.corner_a),
    .corner_b (item.corner_b),
    .corner_c (item.corner_c),
    .corner_d (item.corner_d),
    .op       (op),
    .job      (job)
  );

  thcb_serial u_serial (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LOAD),
    .job   (job),
    .busy  (ser_busy),
    .color (color)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_CLASS;
      S_CLASS: state_next = (op == thcb_pkg::OP_COLOR) ? S_LOAD : S_IDLE;
      S_LOAD:  state_next = S_RUN;
      S_RUN:   if (!ser_busy) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.blue  <= color.blue;
      result.green <= color.green;
      result.red   <= color.red;
      result.band  <= job.band;
    end
  end

  a_accept_classifies: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_CLASS)
    else $error("accepted transaction did not move to classification");

  a_load_starts_serial: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |=> ser_busy)
    else $error("serial unit not busy after load");

  a_serial_idle_outside_run: assert property (@(posedge clk) disable iff (rst)
    ser_busy |-> (state == S_RUN || state == S_LOAD))
    else $error("serial unit busy outside run");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.band <= thcb_pkg::BAND_SNOW)
    else $error("band code out of range");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> result.valid)
    else $error("finished colour transaction not presented");

endmodule

>>> sv/thcb_front.sv
module thcb_front (
  input  logic                                  clk,
  input  logic                                  rst,
  thcb_cfg_if.sink                              cfg,
  input  logic                                  capture,
  input  logic                                  classify,
  input  logic [thcb_pkg::OP_WIDTH-1:0]         opcode,
  input  logic signed [thcb_pkg::ALT_WIDTH-1:0] corner_a,
  input  logic signed [thcb_pkg::ALT_WIDTH-1:0] corner_b,
  input  logic signed [thcb_pkg::ALT_WIDTH-1:0] corner_c,
  input  logic signed [thcb_pkg::ALT_WIDTH-1:0] corner_d,
  output logic [thcb_pkg::OP_WIDTH-1:0]         op,
  output thcb_pkg::job_t                        job
);

  logic signed [thcb_pkg::ALT_WIDTH-1:0]  level [thcb_pkg::NUM_LEVELS];
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  sum;
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  lowest_sum;
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  highest_sum;
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  sum_next;
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  thr [thcb_pkg::NUM_LEVELS];
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  lo;
  logic signed [thcb_pkg::SUM_WIDTH-1:0]  hi;
  logic [thcb_pkg::BAND_WIDTH-1:0]        band_sel;
  thcb_pkg::job_t                         job_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < thcb_pkg::NUM_LEVELS; i++) begin
        level[i] <= thcb_pkg::level_reset(thcb_pkg::CFG_INDEX_WIDTH'(i));
      end
    end else if (cfg.valid && cfg.ready) begin
      level[cfg.index] <= cfg.data;
    end
  end

  assign sum_next = thcb_pkg::SUM_WIDTH'(corner_a) + thcb_pkg::SUM_WIDTH'(corner_b)
                  + thcb_pkg::SUM_WIDTH'(corner_c) + thcb_pkg::SUM_WIDTH'(corner_d);

  always_ff @(posedge clk) begin
    if (capture) begin
      sum <= sum_next;
      op  <= opcode;
    end
  end

  always_comb begin
    for (int i = 0; i < thcb_pkg::NUM_LEVELS; i++) begin
      thr[i] = {level[i], 2'b00};
    end
    if (sum < thr[0]) begin
      band_sel = thcb_pkg::BAND_WATER; lo = lowest_sum; hi = thr[0];
    end else if (sum < thr[1]) begin
      band_sel = thcb_pkg::BAND_SAND;  lo = thr[0];     hi = thr[1];
    end else if (sum < thr[2]) begin
      band_sel = thcb_pkg::BAND_GRASS; lo = thr[1];     hi = thr[2];
    end else if (sum < thr[3]) begin
      band_sel = thcb_pkg::BAND_ROCK;  lo = thr[2];     hi = thr[3];
    end else begin
      band_sel = thcb_pkg::BAND_SNOW;  lo = thr[3];     hi = highest_sum;
    end
    job_next.band = band_sel;
    job_next.num  = thcb_pkg::DIFF_WIDTH'(sum) - thcb_pkg::DIFF_WIDTH'(lo);
    job_next.den  = thcb_pkg::DIFF_WIDTH'(hi) - thcb_pkg::DIFF_WIDTH'(lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_sum  <= thcb_pkg::SUM_MAX;
      highest_sum <= thcb_pkg::SUM_MIN;
    end else if (classify) begin
      if (op == thcb_pkg::OP_TRACK) begin
        if (sum < lowest_sum) lowest_sum <= sum;
        if (sum > highest_sum) highest_sum <= sum;
      end else if (op == thcb_pkg::OP_CLEAR) begin
        lowest_sum  <= thcb_pkg::SUM_MAX;
        highest_sum <= thcb_pkg::SUM_MIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (classify) begin
      job <= job_next;
    end
  end

endmodule

>>> sv/thcb_serial.sv
module thcb_serial (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  thcb_pkg::job_t job,
  output logic           busy,
  output thcb_pkg::bgr_t color
);

  localparam int RW = thcb_pkg::DIFF_WIDTH;

  logic [thcb_pkg::QCNT_WIDTH-1:0] cnt;
  logic [RW-1:0]                   rem;
  logic [RW-2:0]                   den;
  logic                            zero;
  logic                            full;
  thcb_pkg::bgr_t                  base;
  thcb_pkg::bgr_t                  start_color;
  logic [thcb_pkg::ACC_WIDTH-1:0]  acc_b;
  logic [thcb_pkg::ACC_WIDTH-1:0]  acc_g;
  logic [thcb_pkg::ACC_WIDTH-1:0]  acc_r;
  logic [RW-1:0]                   r2;
  logic                            ge;
  logic                            qbit;

  // restoring divide, one quotient bit per cycle, MSB first; each bit
  // also shifts into the color*(128+q) products
  assign r2   = {rem[RW-2:0], 1'b0};
  assign ge   = r2 >= {1'b0, den};
  assign qbit = ge && !zero;

  assign start_color = thcb_pkg::band_color(job.band);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= thcb_pkg::QCNT_WIDTH'(thcb_pkg::Q_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == thcb_pkg::QCNT_WIDTH'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= RW'(job.num[RW-2:0]);
      den   <= job.den[RW-2:0];
      zero  <= (job.den <= 0) || (job.num <= 0);
      full  <= job.num >= job.den;
      base  <= start_color;
      acc_b <= thcb_pkg::ACC_WIDTH'(start_color.blue);
      acc_g <= thcb_pkg::ACC_WIDTH'(start_color.green);
      acc_r <= thcb_pkg::ACC_WIDTH'(start_color.red);
    end else if (busy) begin
      rem   <= ge ? r2 - RW'(den) : r2;
      acc_b <= {acc_b[thcb_pkg::ACC_WIDTH-2:0], 1'b0}
             + (qbit ? thcb_pkg::ACC_WIDTH'(base.blue) : '0);
      acc_g <= {acc_g[thcb_pkg::ACC_WIDTH-2:0], 1'b0}
             + (qbit ? thcb_pkg::ACC_WIDTH'(base.green) : '0);
      acc_r <= {acc_r[thcb_pkg::ACC_WIDTH-2:0], 1'b0}
             + (qbit ? thcb_pkg::ACC_WIDTH'(base.red) : '0);
    end
  end

  // a sum at or past the top of its band scales by 256/256
  always_comb begin
    if (full && !zero) begin
      color = base;
    end else begin
      color.blue  = acc_b[thcb_pkg::ACC_WIDTH-1:thcb_pkg::CHAN_WIDTH];
      color.green = acc_g[thcb_pkg::ACC_WIDTH-1:thcb_pkg::CHAN_WIDTH];
      color.red   = acc_r[thcb_pkg::ACC_WIDTH-1:thcb_pkg::CHAN_WIDTH];
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int NUM_SETTINGS  = 8;
  localparam int PHASE_ITEMS   = 220;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [thcb_pkg::OP_WIDTH-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [thcb_pkg::OP_WIDTH-1:0]         opcode;
    logic signed [thcb_pkg::ALT_WIDTH-1:0] a;
    logic signed [thcb_pkg::ALT_WIDTH-1:0] b;
    logic signed [thcb_pkg::ALT_WIDTH-1:0] c;
    logic signed [thcb_pkg::ALT_WIDTH-1:0] d;
  } cell_t;

  typedef struct packed {
    logic [thcb_pkg::CHAN_WIDTH-1:0] blue;
    logic [thcb_pkg::CHAN_WIDTH-1:0] green;
    logic [thcb_pkg::CHAN_WIDTH-1:0] red;
    logic [thcb_pkg::BAND_WIDTH-1:0] band;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  thcb_cfg_if level_ch ();
  thcb_in_if  cell_ch ();
  thcb_out_if pixel_ch ();

  terrain_height_color_banding u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (level_ch),
    .item   (cell_ch),
    .result (pixel_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // drive-side registers, known from time zero
  logic                                 drv_valid = 1'b0;
  cell_t                                drv_cell  = '0;
  logic                                 rcv_ready = 1'b0;
  logic                                 lvl_valid = 1'b0;
  logic [thcb_pkg::CFG_INDEX_WIDTH-1:0] lvl_index = '0;
  logic [thcb_pkg::ALT_WIDTH-1:0]       lvl_data  = '0;

  assign cell_ch.valid    = drv_valid;
  assign cell_ch.opcode   = drv_cell.opcode;
  assign cell_ch.corner_a = drv_cell.a;
  assign cell_ch.corner_b = drv_cell.b;
  assign cell_ch.corner_c = drv_cell.c;
  assign cell_ch.corner_d = drv_cell.d;
  assign pixel_ch.ready   = rcv_ready;
  assign level_ch.valid   = lvl_valid;
  assign level_ch.index   = lvl_index;
  assign level_ch.data    = lvl_data;

  // predictor state
  logic signed [thcb_pkg::ALT_WIDTH-1:0] band_top [thcb_pkg::NUM_LEVELS];
  longint                                tracked_lo;
  longint                                tracked_hi;

  cell_t  cells_to_send [$];
  pixel_t expected_px [$];

  int queued_count   = 0;
  int accepted_count = 0;
  int results_checked = 0;
  int errors         = 0;
  int band_hits [5]  = '{0, 0, 0, 0, 0};
  bit idle_on        = 1'b1;
  int send_gap       = 0;
  int recv_stall     = 0;

  function automatic logic [3*thcb_pkg::CHAN_WIDTH-1:0] band_tint(
      input logic [thcb_pkg::BAND_WIDTH-1:0] b);
    case (b)
      thcb_pkg::BAND_WATER: return {8'd255, 8'd100, 8'd0};
      thcb_pkg::BAND_SAND:  return {8'd0,   8'd200, 8'd255};
      thcb_pkg::BAND_GRASS: return {8'd0,   8'd255, 8'd0};
      thcb_pkg::BAND_ROCK:  return {8'd128, 8'd128, 8'd128};
      default:              return {8'd255, 8'd255, 8'd255};
    endcase
  endfunction

  // Updates extremes and returns 1 with the pixel for color cells.
  function automatic bit shade_cell(input cell_t cl, output pixel_t px);
    longint s, lo, hi, num, den, w, sd, gr, rk;
    int q;
    logic [thcb_pkg::BAND_WIDTH-1:0] b;
    logic [3*thcb_pkg::CHAN_WIDTH-1:0] tint;
    px = '0;
    s = longint'($signed(cl.a)) + longint'($signed(cl.b))
      + longint'($signed(cl.c)) + longint'($signed(cl.d));
    case (cl.opcode)
      thcb_pkg::OP_TRACK: begin
        if (s < tracked_lo) tracked_lo = s;
        if (s > tracked_hi) tracked_hi = s;
        return 1'b0;
      end
      thcb_pkg::OP_CLEAR: begin
        tracked_lo = thcb_pkg::SUM_MAX;
        tracked_hi = thcb_pkg::SUM_MIN;
        return 1'b0;
      end
      thcb_pkg::OP_COLOR: ;
      default: return 1'b0;
    endcase
    w  = 4 * longint'(band_top[thcb_pkg::REG_WATER_LEVEL]);
    sd = 4 * longint'(band_top[thcb_pkg::REG_SAND_TOP]);
    gr = 4 * longint'(band_top[thcb_pkg::REG_GRASS_TOP]);
    rk = 4 * longint'(band_top[thcb_pkg::REG_ROCK_TOP]);
    if (s < w) begin
      b = thcb_pkg::BAND_WATER; lo = tracked_lo; hi = w;
    end else if (s < sd) begin
      b = thcb_pkg::BAND_SAND; lo = w; hi = sd;
    end else if (s < gr) begin
      b = thcb_pkg::BAND_GRASS; lo = sd; hi = gr;
    end else if (s < rk) begin
      b = thcb_pkg::BAND_ROCK; lo = gr; hi = rk;
    end else begin
      b = thcb_pkg::BAND_SNOW; lo = rk; hi = tracked_hi;
    end
    num = s - lo;
    den = hi - lo;
    if (den <= 0 || num <= 0) q = 0;
    else if (num >= den) q = 128;
    else q = int'((num * 128) / den);
    tint = band_tint(b);
    px.blue  = thcb_pkg::CHAN_WIDTH'((int'(tint[23:16]) * (128 + q)) >> 8);
    px.green = thcb_pkg::CHAN_WIDTH'((int'(tint[15:8]) * (128 + q)) >> 8);
    px.red   = thcb_pkg::CHAN_WIDTH'((int'(tint[7:0]) * (128 + q)) >> 8);
    px.band  = b;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : sender
    pixel_t px;
    if (rst) begin
      drv_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (drv_valid && cell_ch.ready) begin
        if (shade_cell(drv_cell, px)) expected_px.push_back(px);
        accepted_count++;
      end
      if (!drv_valid || cell_ch.ready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          drv_valid <= 1'b0;
        end else if (cells_to_send.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
          // idle burst: drop valid and load send_gap with 0 to 16
          send_gap  <= $urandom_range(0, 16);
          drv_valid <= 1'b0;
        end else if (cells_to_send.size() != 0) begin
          drv_cell  <= cells_to_send.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    pixel_t want;
    if (rst) begin
      rcv_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (pixel_ch.valid && rcv_ready) begin
        if (expected_px.size() == 0) begin
          $error("unexpected pixel: band %0d blue %0d green %0d red %0d",
                 pixel_ch.band, pixel_ch.blue, pixel_ch.green, pixel_ch.red);
          errors++;
        end else begin
          want = expected_px.pop_front();
          results_checked++;
          band_hits[want.band]++;
          if (pixel_ch.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, pixel_ch.blue);
            errors++;
          end
          if (pixel_ch.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, pixel_ch.green);
            errors++;
          end
          if (pixel_ch.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, pixel_ch.red);
            errors++;
          end
          if (pixel_ch.band !== want.band) begin
            $error("band: expected %0d, got %0d", want.band, pixel_ch.band);
            errors++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        rcv_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        recv_stall <= $urandom_range(0, 16);
        rcv_ready  <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [thcb_pkg::ALT_WIDTH-1:0] clamp_alt(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return thcb_pkg::ALT_WIDTH'(v);
  endfunction

  task automatic push_cell(input logic [thcb_pkg::OP_WIDTH-1:0] op,
                           input logic signed [thcb_pkg::ALT_WIDTH-1:0] a, b, c, d);
    cells_to_send.push_back('{opcode: op, a: a, b: b, c: c, d: d});
    queued_count++;
  endtask

  // Corners jittered around one altitude, often near a threshold so the
  // sum lands on band edges.
  task automatic push_near(input logic [thcb_pkg::OP_WIDTH-1:0] op);
    int r, centre;
    r = $urandom_range(0, 99);
    if (r < 45)
      centre = int'(band_top[$urandom_range(0, thcb_pkg::NUM_LEVELS - 1)])
             + int'($urandom_range(0, 80)) - 40;
    else if (r < 60)
      centre = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
                                    : -32768 + int'($urandom_range(0, 40));
    else
      centre = int'($urandom_range(0, 65535)) - 32768;
    push_cell(op, clamp_alt(centre + int'($urandom_range(0, 16)) - 8),
                  clamp_alt(centre + int'($urandom_range(0, 16)) - 8),
                  clamp_alt(centre + int'($urandom_range(0, 16)) - 8),
                  clamp_alt(centre + int'($urandom_range(0, 16)) - 8));
  endtask

  task automatic random_phase(input int n);
    int made, k;
    logic [thcb_pkg::OP_WIDTH-1:0] op;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 2) == 0) begin
          push_cell(thcb_pkg::OP_CLEAR,
                    thcb_pkg::ALT_WIDTH'($urandom), thcb_pkg::ALT_WIDTH'($urandom),
                    thcb_pkg::ALT_WIDTH'($urandom), thcb_pkg::ALT_WIDTH'($urandom));
          made++;
        end
        k = $urandom_range(1, 5);
        repeat (k) push_near(thcb_pkg::OP_TRACK);
        made += k;
        k = $urandom_range(1, 6);
        repeat (k) push_near(thcb_pkg::OP_COLOR);
        made += k;
      end else begin
        op = thcb_pkg::OP_WIDTH'($urandom_range(0, 3));
        push_cell(op, thcb_pkg::ALT_WIDTH'($urandom), thcb_pkg::ALT_WIDTH'($urandom),
                  thcb_pkg::ALT_WIDTH'($urandom), thcb_pkg::ALT_WIDTH'($urandom));
        if (op != OP_UNUSED) made++;
      end
    end
  endtask

  // wait for every cell to be taken and every pixel to come back
  task automatic settle();
    while (accepted_count != queued_count || expected_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_level(input logic [thcb_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic signed [thcb_pkg::ALT_WIDTH-1:0] v);
    @(posedge clk);
    lvl_valid <= 1'b1;
    lvl_index <= idx;
    lvl_data  <= v;
    do @(posedge clk); while (!level_ch.ready);
    band_top[idx] = v;
    lvl_valid <= 1'b0;
  endtask

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("terrain_height_color_banding verification failed");
    $finish;
  end

  initial begin : stimulus
    int w, s, g, r;
    band_top[thcb_pkg::REG_WATER_LEVEL] = 16'sd0;
    band_top[thcb_pkg::REG_SAND_TOP]    = 16'sd1024;
    band_top[thcb_pkg::REG_GRASS_TOP]   = 16'sd4096;
    band_top[thcb_pkg::REG_ROCK_TOP]    = 16'sd8192;
    tracked_lo = thcb_pkg::SUM_MAX;
    tracked_hi = thcb_pkg::SUM_MIN;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed cells at the reset thresholds
    push_cell(thcb_pkg::OP_COLOR, 0, 0, 0, 0);                // extremes never tracked
    push_cell(thcb_pkg::OP_COLOR, -32768, -32768, -32768, -32768);
    push_cell(thcb_pkg::OP_COLOR, 32767, 32767, 32767, 32767);
    push_cell(OP_UNUSED, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    push_cell(thcb_pkg::OP_TRACK, 0, 0, 0, 0);
    push_cell(thcb_pkg::OP_COLOR, -1, -1, -1, -1);            // zero-width water band
    push_cell(thcb_pkg::OP_COLOR, 1, 0, 0, 0);
    push_cell(thcb_pkg::OP_TRACK, -32768, -32768, -32768, -32768);
    push_cell(thcb_pkg::OP_COLOR, -1, -1, -1, -2);
    push_cell(thcb_pkg::OP_COLOR, -32768, -32768, -32768, -32768);
    push_cell(thcb_pkg::OP_CLEAR, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    push_cell(thcb_pkg::OP_TRACK, 8192, 8192, 8192, 8192);
    push_cell(thcb_pkg::OP_COLOR, 8192, 8192, 8192, 8192);    // zero-width snow band
    push_cell(thcb_pkg::OP_TRACK, 32767, 32767, 32767, 32767);
    push_cell(thcb_pkg::OP_COLOR, 32767, 32767, 32767, 32767); // at the top: full scale
    push_cell(thcb_pkg::OP_COLOR, 20000, 20000, 20000, 20000);
    push_cell(thcb_pkg::OP_COLOR, 8191, 8192, 8192, 8192);
    push_cell(thcb_pkg::OP_COLOR, 4096, 4096, 4096, 4096);
    push_cell(thcb_pkg::OP_COLOR, 1024, 1024, 1024, 1024);
    push_cell(thcb_pkg::OP_COLOR, 2000, 2000, 2000, 2000);
    push_cell(thcb_pkg::OP_TRACK, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555);
    push_cell(OP_UNUSED, -32768, 32767, -32768, 32767);
    push_cell(thcb_pkg::OP_CLEAR, 0, 0, 0, 0);
    push_cell(thcb_pkg::OP_COLOR, 32767, 32767, 32767, 32767); // snow after clear
    random_phase(PHASE_ITEMS);
    settle();

    for (int phase = 1; phase < NUM_SETTINGS; phase++) begin
      case (phase)
        1: begin
          w = int'($urandom_range(0, 32768)) - 32768;
          s = w + int'($urandom_range(0, 8000));
          g = s + int'($urandom_range(0, 8000));
          r = g + int'($urandom_range(0, 8000));
        end
        2: begin
          w = -32768; s = -32768; g = -32768; r = -32768;
        end
        3: begin
          w = 32767; s = 32767; g = 32767; r = 32767;
        end
        4: begin
          // unordered thresholds
          w = int'($urandom_range(0, 65535)) - 32768;
          s = int'($urandom_range(0, 65535)) - 32768;
          g = int'($urandom_range(0, 65535)) - 32768;
          r = int'($urandom_range(0, 65535)) - 32768;
        end
        5: begin
          // sand and rock collapse to zero width
          w = int'($urandom_range(0, 20000)) - 20000;
          s = w;
          g = w + int'($urandom_range(1, 20000));
          r = g;
        end
        6: begin
          w = -32768; s = -1; g = 0; r = 32767;
        end
        default: begin
          w = int'($urandom_range(0, 60000)) - 30000;
          s = w + int'($urandom_range(0, 200));
          g = s + int'($urandom_range(0, 200));
          r = g + int'($urandom_range(0, 200));
        end
      endcase
      write_level(thcb_pkg::REG_WATER_LEVEL, clamp_alt(w));
      write_level(thcb_pkg::REG_SAND_TOP, clamp_alt(s));
      write_level(thcb_pkg::REG_GRASS_TOP, clamp_alt(g));
      write_level(thcb_pkg::REG_ROCK_TOP, clamp_alt(r));
      @(negedge clk);
      idle_on = (phase != 3) && (phase != NUM_SETTINGS - 1);
      random_phase(PHASE_ITEMS);
      settle();
    end

    $display("checked %0d color pixels from %0d accepted cells over %0d threshold settings",
             results_checked, accepted_count, NUM_SETTINGS);
    $display("band hits: water %0d, sand %0d, grass %0d, rock %0d, snow %0d",
             band_hits[0], band_hits[1], band_hits[2], band_hits[3], band_hits[4]);
    if (errors == 0) begin
      $display("terrain_height_color_banding verification clean");
    end else begin
      $display("terrain_height_color_banding verification failed");
    end
    $finish;
  end

endmodule
